// ===== sv/json_string_unescape_utf8_defines.svh =====
// Assertion macros for the JSON string unescaper.
// Each macro samples on clk_i and is disabled while rst_ni is low.
`ifndef JSON_STRING_UNESCAPE_UTF8_DEFINES_SVH
`define JSON_STRING_UNESCAPE_UTF8_DEFINES_SVH

// Condition must hold in the same cycle as the antecedent.
`define JSU_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Condition must hold in the cycle after the antecedent.
`define JSU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/jsu_pkg.sv =====
// Shared types, character codes and helper functions of the JSON string unescaper.
// No dependencies; every other source file but the defines header imports this package.
package jsu_pkg;

  localparam int unsigned QDEPTH   = 16;
  localparam int unsigned QIDX_W   = $clog2(QDEPTH);
  localparam int unsigned EB_DEPTH = 4;
  localparam int unsigned EBCNT_W  = $clog2(EB_DEPTH + 1);

  typedef logic [QIDX_W:0]            qptr_t;
  typedef logic [EBCNT_W-1:0]         eb_cnt_t;
  typedef logic [EB_DEPTH-1:0][7:0]   ebytes_t;

  localparam logic [7:0] CH_BSLASH  = 8'h5C;
  localparam logic [7:0] CH_LOWER_U = 8'h75;
  localparam logic [7:0] CH_LOWER_N = 8'h6E;
  localparam logic [7:0] CH_LOWER_R = 8'h72;
  localparam logic [7:0] CH_LOWER_T = 8'h74;
  localparam logic [7:0] CH_LOWER_B = 8'h62;
  localparam logic [7:0] CH_LOWER_F = 8'h66;
  localparam logic [7:0] CH_QUOTE   = 8'h22;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_LF      = 8'h0A;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_BS      = 8'h08;
  localparam logic [7:0] CH_FF      = 8'h0C;
  localparam logic [7:0] CH_DIGIT_0 = 8'h30;
  localparam logic [7:0] CH_DIGIT_9 = 8'h39;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_F = 8'h46;
  localparam logic [7:0] CH_LOWER_A = 8'h61;

  localparam logic [15:0] HI_SUR_MIN = 16'hD800;
  localparam logic [15:0] HI_SUR_MAX = 16'hDBFF;
  localparam logic [15:0] LO_SUR_MIN = 16'hDC00;
  localparam logic [15:0] LO_SUR_MAX = 16'hDFFF;
  localparam logic [20:0] SUPP_BASE  = 21'h10000;
  localparam logic [20:0] UTF8_MAX1  = 21'h7F;
  localparam logic [20:0] UTF8_MAX2  = 21'h7FF;
  localparam logic [20:0] UTF8_MAX3  = 21'hFFFF;
  localparam logic [7:0]  UTF8_LEAD2 = 8'hC0;
  localparam logic [7:0]  UTF8_LEAD3 = 8'hE0;
  localparam logic [7:0]  UTF8_LEAD4 = 8'hF0;
  localparam logic [7:0]  UTF8_CONT  = 8'h80;
  localparam logic [1:0]  DIG_LAST   = 2'd3;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
  } out_item_t;

  typedef struct packed {
    logic [7:0] raw;
    logic       last;
    logic       is_bslash;
    logic       is_u;
    logic       is_hex;
    logic [3:0] hex_val;
    logic       esc_known;
    logic [7:0] esc_val;
  } entry_t;

  typedef struct packed {
    logic full;
    logic avail;
  } qstat_t;

  typedef struct packed {
    qptr_t rd_ptr;
    qptr_t free_ptr;
  } qreq_t;

  typedef struct packed {
    logic end_pend;
    logic hb_valid;
    logic last_step;
  } bk_status_t;

  typedef struct packed {
    ebytes_t bytes;
    eb_cnt_t len;
  } utf8_t;

  typedef enum logic [5:0] {
    MODE_PLAIN  = 6'b000001,
    MODE_SLASH  = 6'b000010,
    MODE_HEX1   = 6'b000100,
    MODE_SLASH2 = 6'b001000,
    MODE_U2     = 6'b010000,
    MODE_HEX2   = 6'b100000
  } mode_e;

  function automatic entry_t classify(input in_item_t item);
    entry_t     e;
    logic [7:0] b;
    b           = item.in_byte;
    e.raw       = b;
    e.last      = item.in_last;
    e.is_bslash = (b == CH_BSLASH);
    e.is_u      = (b == CH_LOWER_U);
    e.is_hex    = 1'b0;
    e.hex_val   = 4'h0;
    if (b >= CH_DIGIT_0 && b <= CH_DIGIT_9) begin
      e.is_hex  = 1'b1;
      e.hex_val = 4'(b - CH_DIGIT_0);
    end else if (b >= CH_UPPER_A && b <= CH_UPPER_F) begin
      e.is_hex  = 1'b1;
      e.hex_val = 4'(b - CH_UPPER_A + 8'd10);
    end else if (b >= CH_LOWER_A && b <= CH_LOWER_F) begin
      e.is_hex  = 1'b1;
      e.hex_val = 4'(b - CH_LOWER_A + 8'd10);
    end
    e.esc_known = 1'b1;
    unique case (b)
      CH_LOWER_N: e.esc_val = CH_LF;
      CH_LOWER_R: e.esc_val = CH_CR;
      CH_LOWER_T: e.esc_val = CH_TAB;
      CH_QUOTE:   e.esc_val = CH_QUOTE;
      CH_BSLASH:  e.esc_val = CH_BSLASH;
      CH_SLASH:   e.esc_val = CH_SLASH;
      CH_LOWER_B: e.esc_val = CH_BS;
      CH_LOWER_F: e.esc_val = CH_FF;
      default: begin
        e.esc_known = 1'b0;
        e.esc_val   = 8'h00;
      end
    endcase
    return e;
  endfunction

  function automatic utf8_t utf8_encode(input logic [20:0] cp);
    utf8_t r;
    r.bytes = '0;
    if (cp <= UTF8_MAX1) begin
      r.len      = eb_cnt_t'(1);
      r.bytes[0] = cp[7:0];
    end else if (cp <= UTF8_MAX2) begin
      r.len      = eb_cnt_t'(2);
      r.bytes[0] = UTF8_LEAD2 | {3'b000, cp[10:6]};
      r.bytes[1] = UTF8_CONT | {2'b00, cp[5:0]};
    end else if (cp <= UTF8_MAX3) begin
      r.len      = eb_cnt_t'(3);
      r.bytes[0] = UTF8_LEAD3 | {4'b0000, cp[15:12]};
      r.bytes[1] = UTF8_CONT | {2'b00, cp[11:6]};
      r.bytes[2] = UTF8_CONT | {2'b00, cp[5:0]};
    end else begin
      r.len      = eb_cnt_t'(4);
      r.bytes[0] = UTF8_LEAD4 | {5'b00000, cp[20:18]};
      r.bytes[1] = UTF8_CONT | {2'b00, cp[17:12]};
      r.bytes[2] = UTF8_CONT | {2'b00, cp[11:6]};
      r.bytes[3] = UTF8_CONT | {2'b00, cp[5:0]};
    end
    return r;
  endfunction

endpackage

// ===== sv/jsu_front.sv =====
// Input side of the unescaper: takes raw byte transactions and tags each with its class.
// Depends on jsu_pkg; feeds jsu_queue.
module jsu_front import jsu_pkg::*; (
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_item_t in_data_i,
  input  qstat_t   qstat_i,
  output logic     wr_en_o,
  output entry_t   wr_entry_o
);

  assign in_stall_o = qstat_i.full;
  assign wr_en_o    = in_valid_i && !qstat_i.full;
  assign wr_entry_o = classify(in_data_i);

endmodule

// ===== sv/jsu_queue.sv =====
// Rewindable byte queue between front and back; entries stay until the back frees them.
// Depends on jsu_pkg.
module jsu_queue import jsu_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   wr_en_i,
  input  entry_t wr_entry_i,
  input  qreq_t  qreq_i,
  output qstat_t qstat_o,
  output entry_t rd_entry_o
);

  entry_t mem_q [QDEPTH];
  qptr_t  wr_q, wr_d;

  assign wr_d = wr_en_i ? wr_q + qptr_t'(1) : wr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
    end else begin
      wr_q <= wr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_q[QIDX_W-1:0]] <= wr_entry_i;
    end
  end

  assign rd_entry_o    = mem_q[qreq_i.rd_ptr[QIDX_W-1:0]];
  assign qstat_o.avail = (qreq_i.rd_ptr != wr_q);
  assign qstat_o.full  = (wr_q[QIDX_W] != qreq_i.free_ptr[QIDX_W]) &&
                         (wr_q[QIDX_W-1:0] == qreq_i.free_ptr[QIDX_W-1:0]);

endmodule

// ===== sv/jsu_back.sv =====
// Decode engine of the unescaper: escape state machine, UTF-8 emit buffer and output register.
// Depends on jsu_pkg; reads entries from jsu_queue and rewinds it on a failed escape.
module jsu_back import jsu_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  entry_t     entry_i,
  input  qstat_t     qstat_i,
  output qreq_t      qreq_o,
  output bk_status_t status_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output out_item_t  out_data_o
);

  mode_e       mode_q, mode_d;
  qptr_t       rd_q, rd_d, esc_q, esc_d;
  logic [15:0] acc_q, acc_d;
  logic [1:0]  dig_q, dig_d;
  logic [9:0]  hs_q, hs_d;
  ebytes_t     eb_q, eb_d;
  eb_cnt_t     eb_cnt_q, eb_cnt_d;
  logic        hb_valid_q, hb_valid_d;
  logic [7:0]  hb_q, hb_d;
  logic        last_step_q, last_step_d;
  logic        end_pend_q, end_pend_d;
  logic        out_valid_q, out_valid_d;
  out_item_t   out_q, out_d;

  logic        out_can, go, drain, proc, end_act, fin, do_fail, push;
  out_item_t   push_data;
  utf8_t       ld;
  logic [15:0] acc_n;
  logic [20:0] cp_pair;
  qptr_t       fail_ptr;
  logic        acc_hi, acc_lo;

  assign out_can  = !out_valid_q || !out_stall_i;
  assign drain    = (eb_cnt_q != '0) && out_can;
  assign go       = (eb_cnt_q == '0) || ((eb_cnt_q == eb_cnt_t'(1)) && out_can);
  assign proc     = go && !end_pend_q && qstat_i.avail;
  assign end_act  = go && end_pend_q && (mode_q != MODE_PLAIN);
  assign fin      = end_pend_q && (mode_q == MODE_PLAIN) && (eb_cnt_q == '0) && out_can;
  assign fail_ptr = esc_q + qptr_t'(2);
  assign acc_n    = {acc_q[11:0], entry_i.hex_val};
  assign cp_pair  = SUPP_BASE + {1'b0, hs_q, acc_n[9:0]};
  assign acc_hi   = (acc_n >= HI_SUR_MIN) && (acc_n <= HI_SUR_MAX);
  assign acc_lo   = (acc_n >= LO_SUR_MIN) && (acc_n <= LO_SUR_MAX);

  always_comb begin
    mode_d      = mode_q;
    rd_d        = rd_q;
    esc_d       = esc_q;
    acc_d       = acc_q;
    dig_d       = dig_q;
    hs_d        = hs_q;
    eb_d        = eb_q;
    eb_cnt_d    = eb_cnt_q;
    hb_valid_d  = hb_valid_q;
    hb_d        = hb_q;
    last_step_d = last_step_q;
    end_pend_d  = end_pend_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    ld          = '0;
    do_fail     = 1'b0;
    push        = 1'b0;
    push_data   = '0;

    // drain one byte; during a final transaction keep one byte back to tag it
    if (drain) begin
      eb_d     = eb_q >> 8;
      eb_cnt_d = eb_cnt_q - eb_cnt_t'(1);
      if (last_step_q) begin
        if (hb_valid_q) begin
          push      = 1'b1;
          push_data = '{out_byte: hb_q, out_last: 1'b0};
        end
        hb_d       = eb_q[0];
        hb_valid_d = 1'b1;
      end else begin
        push      = 1'b1;
        push_data = '{out_byte: eb_q[0], out_last: 1'b0};
      end
    end

    if (fin) begin
      if (hb_valid_q) begin
        push      = 1'b1;
        push_data = '{out_byte: hb_q, out_last: 1'b1};
      end
      hb_valid_d  = 1'b0;
      last_step_d = 1'b0;
      end_pend_d  = 1'b0;
    end

    if (proc) begin
      rd_d = rd_q + qptr_t'(1);
      if (entry_i.last) begin
        last_step_d = 1'b1;
      end
      unique case (mode_q)
        MODE_PLAIN: begin
          if (entry_i.is_bslash) begin
            esc_d  = rd_q;
            mode_d = MODE_SLASH;
          end else begin
            ld.len      = eb_cnt_t'(1);
            ld.bytes[0] = entry_i.raw;
          end
        end
        MODE_SLASH: begin
          mode_d = MODE_PLAIN;
          if (entry_i.esc_known) begin
            ld.len      = eb_cnt_t'(1);
            ld.bytes[0] = entry_i.esc_val;
          end else if (entry_i.is_u) begin
            acc_d  = '0;
            dig_d  = '0;
            mode_d = MODE_HEX1;
          end else begin
            ld.len      = eb_cnt_t'(2);
            ld.bytes[0] = CH_BSLASH;
            ld.bytes[1] = entry_i.raw;
          end
        end
        MODE_HEX1: begin
          if (!entry_i.is_hex) begin
            do_fail = 1'b1;
          end else begin
            acc_d = acc_n;
            dig_d = dig_q + 2'd1;
            if (dig_q == DIG_LAST) begin
              if (acc_hi) begin
                hs_d   = acc_n[9:0];
                mode_d = MODE_SLASH2;
              end else if (acc_lo) begin
                do_fail = 1'b1;
              end else begin
                mode_d = MODE_PLAIN;
                ld     = utf8_encode({5'b00000, acc_n});
              end
            end
          end
        end
        MODE_SLASH2: begin
          if (entry_i.is_bslash) begin
            mode_d = MODE_U2;
          end else begin
            do_fail = 1'b1;
          end
        end
        MODE_U2: begin
          if (entry_i.is_u) begin
            acc_d  = '0;
            dig_d  = '0;
            mode_d = MODE_HEX2;
          end else begin
            do_fail = 1'b1;
          end
        end
        MODE_HEX2: begin
          if (!entry_i.is_hex) begin
            do_fail = 1'b1;
          end else begin
            acc_d = acc_n;
            dig_d = dig_q + 2'd1;
            if (dig_q == DIG_LAST) begin
              if (acc_lo) begin
                mode_d = MODE_PLAIN;
                ld     = utf8_encode(cp_pair);
              end else begin
                do_fail = 1'b1;
              end
            end
          end
        end
        default: mode_d = MODE_PLAIN;
      endcase
      if (entry_i.last && !do_fail) begin
        end_pend_d = 1'b1;
      end
    end

    // end of string with an escape still open
    if (end_act) begin
      if (mode_q == MODE_SLASH) begin
        mode_d      = MODE_PLAIN;
        ld.len      = eb_cnt_t'(1);
        ld.bytes[0] = CH_BSLASH;
      end else begin
        do_fail = 1'b1;
        if (fail_ptr != rd_q) begin
          end_pend_d = 1'b0;
        end
      end
    end

    // give backslash and u, then rewind to replay the bytes after the u
    if (do_fail) begin
      mode_d      = MODE_PLAIN;
      rd_d        = fail_ptr;
      ld.len      = eb_cnt_t'(2);
      ld.bytes[0] = CH_BSLASH;
      ld.bytes[1] = CH_LOWER_U;
    end

    if (proc || end_act) begin
      eb_d     = ld.bytes;
      eb_cnt_d = ld.len;
    end

    if (push) begin
      out_valid_d = 1'b1;
      out_d       = push_data;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_PLAIN;
      rd_q        <= '0;
      esc_q       <= '0;
      dig_q       <= '0;
      eb_cnt_q    <= '0;
      hb_valid_q  <= 1'b0;
      last_step_q <= 1'b0;
      end_pend_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      mode_q      <= mode_d;
      rd_q        <= rd_d;
      esc_q       <= esc_d;
      dig_q       <= dig_d;
      eb_cnt_q    <= eb_cnt_d;
      hb_valid_q  <= hb_valid_d;
      last_step_q <= last_step_d;
      end_pend_q  <= end_pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    hs_q  <= hs_d;
    eb_q  <= eb_d;
    hb_q  <= hb_d;
    out_q <= out_d;
  end

  assign qreq_o.rd_ptr   = rd_q;
  assign qreq_o.free_ptr = (mode_q == MODE_PLAIN) ? rd_q : esc_q;

  assign status_o.end_pend  = end_pend_q;
  assign status_o.hb_valid  = hb_valid_q;
  assign status_o.last_step = last_step_q;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== sv/json_string_unescape_utf8.sv =====
// JSON string body unescaper, top level; instantiates jsu_front, jsu_queue and jsu_back
// and depends on jsu_pkg and json_string_unescape_utf8_defines.svh.
// One raw byte of a string body per input transaction, in_last on the final byte; one decoded
// byte per output transaction, out_last on the final decoded byte of each string. Escapes
// n r t " \ / b f map to single bytes, \uXXXX and surrogate pairs become 1 to 4 bytes of UTF-8,
// and a bad \u escape is given as backslash and u with the bytes after the u decoded again.
// Bytes pass through a 16-entry queue that keeps an open escape until it resolves. The back end
// gives at most one decoded byte per cycle, so while the output is not stalled plain text and
// short escapes run at one input byte per cycle, and a UTF-8 sequence is given a byte at a time.
// A failed \u escape rereads its held bytes from the queue at one byte per cycle, and at the end
// of each string the final byte is held back, then flushed and tagged with out_last.
`include "json_string_unescape_utf8_defines.svh"
module json_string_unescape_utf8 import jsu_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  qstat_t     qstat;
  qreq_t      qreq;
  entry_t     wr_entry, rd_entry;
  logic       wr_en;
  bk_status_t bk_stat;

  jsu_front u_front (
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .qstat_i    (qstat),
    .wr_en_o    (wr_en),
    .wr_entry_o (wr_entry)
  );

  jsu_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (wr_en),
    .wr_entry_i (wr_entry),
    .qreq_i     (qreq),
    .qstat_o    (qstat),
    .rd_entry_o (rd_entry)
  );

  jsu_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .entry_i     (rd_entry),
    .qstat_i     (qstat),
    .qreq_o      (qreq),
    .status_o    (bk_stat),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  `JSU_ASSERT_IMPLY(a_end_in_last_step, bk_stat.end_pend, bk_stat.last_step, "end pending outside final transaction")
  `JSU_ASSERT_IMPLY(a_hold_in_last_step, bk_stat.hb_valid, bk_stat.last_step, "held byte outside final transaction")
  `JSU_ASSERT_IMPLY(a_last_hold_empty, out_valid_o && !out_stall_i && out_data_o.out_last, !bk_stat.hb_valid, "byte held behind final output")
  `JSU_ASSERT_NEXT(a_end_clears_step, bk_stat.end_pend && !bk_stat.last_step, 1'b0, "end pending without step")

endmodule

// ===== tb/json_string_unescape_utf8_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for json_string_unescape_utf8: watches both valid/stall channels, decodes each
// accepted input transaction itself and compares every output transaction in order.
// Depends on jsu_pkg for the transaction types, decoder states and character codes.
module jsu_decode_checker import jsu_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_stall_i,
  input  in_item_t  in_data_i,
  input  logic      out_valid_i,
  input  logic      out_stall_i,
  input  out_item_t out_data_i,
  output int        errors_o,
  output int        pending_o,
  output int        checked_o
);

  localparam int STEP_CAP = 12;
  localparam int HOLD_CAP = 12;

  mode_e       dec_mode;
  logic [7:0]  esc_bytes [HOLD_CAP];
  int          esc_len;
  logic [15:0] hex_acc;
  logic [15:0] hi_unit;
  logic [7:0]  step_bytes [$];
  logic [7:0]  replay_q [$];
  out_item_t   expected_q [$];

  function automatic int nibble_of(logic [7:0] c);
    if (c >= CH_DIGIT_0 && c <= CH_DIGIT_9) return int'(c - CH_DIGIT_0);
    if (c >= CH_UPPER_A && c <= CH_UPPER_F) return int'(c - CH_UPPER_A) + 10;
    if (c >= CH_LOWER_A && c <= CH_LOWER_F) return int'(c - CH_LOWER_A) + 10;
    return -1;
  endfunction

  function automatic void push_decoded(logic [7:0] b);
    if (step_bytes.size() < STEP_CAP) step_bytes.push_back(b);
  endfunction

  function automatic void push_utf8(logic [20:0] cp);
    if (cp < 21'h80) begin
      push_decoded(cp[7:0]);
    end else if (cp < 21'h800) begin
      push_decoded({3'b110, cp[10:6]});
      push_decoded({2'b10, cp[5:0]});
    end else if (cp < 21'h10000) begin
      push_decoded({4'b1110, cp[15:12]});
      push_decoded({2'b10, cp[11:6]});
      push_decoded({2'b10, cp[5:0]});
    end else begin
      push_decoded({5'b11110, cp[20:18]});
      push_decoded({2'b10, cp[17:12]});
      push_decoded({2'b10, cp[11:6]});
      push_decoded({2'b10, cp[5:0]});
    end
  endfunction

  function automatic void hold_esc_byte(logic [7:0] b);
    if (esc_len < HOLD_CAP) begin
      esc_bytes[esc_len] = b;
      esc_len++;
    end
  endfunction

  // Give back the backslash and u, then queue the bytes after the u for decoding again.
  function automatic void abort_u_escape();
    logic [7:0] tail [$];
    for (int i = 2; i < esc_len; i++) tail.push_back(esc_bytes[i]);
    dec_mode = MODE_PLAIN;
    esc_len  = 0;
    push_decoded(CH_BSLASH);
    push_decoded(CH_LOWER_U);
    replay_q = {tail, replay_q};
  endfunction

  function automatic void decode_byte(logic [7:0] b);
    int          nib;
    logic [20:0] cp;
    case (dec_mode)
      MODE_PLAIN: begin
        if (b == CH_BSLASH) begin
          esc_len = 0;
          hold_esc_byte(b);
          dec_mode = MODE_SLASH;
        end else begin
          push_decoded(b);
        end
      end
      MODE_SLASH: begin
        dec_mode = MODE_PLAIN;
        esc_len  = 0;
        case (b)
          CH_LOWER_N: push_decoded(CH_LF);
          CH_LOWER_R: push_decoded(CH_CR);
          CH_LOWER_T: push_decoded(CH_TAB);
          CH_QUOTE:   push_decoded(CH_QUOTE);
          CH_BSLASH:  push_decoded(CH_BSLASH);
          CH_SLASH:   push_decoded(CH_SLASH);
          CH_LOWER_B: push_decoded(CH_BS);
          CH_LOWER_F: push_decoded(CH_FF);
          CH_LOWER_U: begin
            esc_len = 1;
            hold_esc_byte(b);
            hex_acc  = '0;
            dec_mode = MODE_HEX1;
          end
          default: begin
            push_decoded(CH_BSLASH);
            push_decoded(b);
          end
        endcase
      end
      MODE_HEX1: begin
        hold_esc_byte(b);
        nib = nibble_of(b);
        if (nib < 0) begin
          abort_u_escape();
        end else begin
          hex_acc = {hex_acc[11:0], nib[3:0]};
          if (esc_len >= 6) begin
            if (hex_acc >= HI_SUR_MIN && hex_acc <= HI_SUR_MAX) begin
              hi_unit  = hex_acc;
              dec_mode = MODE_SLASH2;
            end else if (hex_acc >= LO_SUR_MIN && hex_acc <= LO_SUR_MAX) begin
              abort_u_escape();
            end else begin
              dec_mode = MODE_PLAIN;
              esc_len  = 0;
              push_utf8(21'(hex_acc));
            end
          end
        end
      end
      MODE_SLASH2: begin
        hold_esc_byte(b);
        if (b != CH_BSLASH) abort_u_escape();
        else dec_mode = MODE_U2;
      end
      MODE_U2: begin
        hold_esc_byte(b);
        if (b != CH_LOWER_U) begin
          abort_u_escape();
        end else begin
          hex_acc  = '0;
          dec_mode = MODE_HEX2;
        end
      end
      default: begin
        hold_esc_byte(b);
        nib = nibble_of(b);
        if (nib < 0) begin
          abort_u_escape();
        end else begin
          hex_acc = {hex_acc[11:0], nib[3:0]};
          if (esc_len >= 12) begin
            if (hex_acc >= LO_SUR_MIN && hex_acc <= LO_SUR_MAX) begin
              cp = SUPP_BASE + ((21'(hi_unit) - 21'(HI_SUR_MIN)) << 10)
                 + (21'(hex_acc) - 21'(LO_SUR_MIN));
              dec_mode = MODE_PLAIN;
              esc_len  = 0;
              push_utf8(cp);
            end else begin
              abort_u_escape();
            end
          end
        end
      end
    endcase
  endfunction

  function automatic void run_replay();
    while (replay_q.size() > 0) decode_byte(replay_q.pop_front());
  endfunction

  function automatic void decode_item(in_item_t item);
    out_item_t r;
    step_bytes.delete();
    replay_q.delete();
    replay_q.push_back(item.in_byte);
    run_replay();
    if (item.in_last) begin
      while (dec_mode != MODE_PLAIN) begin
        if (dec_mode == MODE_SLASH) begin
          dec_mode = MODE_PLAIN;
          esc_len  = 0;
          push_decoded(CH_BSLASH);
        end else begin
          abort_u_escape();
          run_replay();
        end
      end
    end
    foreach (step_bytes[i]) begin
      r.out_byte = step_bytes[i];
      r.out_last = item.in_last && (i == step_bytes.size() - 1);
      expected_q.push_back(r);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      dec_mode  = MODE_PLAIN;
      esc_len   = 0;
      hex_acc   = '0;
      hi_unit   = '0;
      expected_q.delete();
      errors_o  = 0;
      checked_o = 0;
    end else begin
      if (in_valid_i && !in_stall_i) decode_item(in_data_i);
      if (out_valid_i && !out_stall_i) begin
        checked_o++;
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected output, expected none, actual byte %02h last %0b",
                   $time, out_data_i.out_byte, out_data_i.out_last);
          errors_o++;
        end else begin
          want = expected_q.pop_front();
          if (out_data_i.out_byte !== want.out_byte) begin
            $display("%0t: out_byte mismatch, expected %02h, actual %02h",
                     $time, want.out_byte, out_data_i.out_byte);
            errors_o++;
          end
          if (out_data_i.out_last !== want.out_last) begin
            $display("%0t: out_last mismatch, expected %0b, actual %0b",
                     $time, want.out_last, out_data_i.out_last);
            errors_o++;
          end
        end
      end
    end
    pending_o = expected_q.size();
  end

endmodule

// ===== tb/json_string_unescape_utf8_tb.sv =====
`timescale 1ns / 1ps
// Top testbench for json_string_unescape_utf8: clock, reset, string stimulus and receiver stall.
// Depends on jsu_pkg, the block itself and jsu_decode_checker, which does all checking.
module json_string_unescape_utf8_tb;
  import jsu_pkg::*;

  localparam int RANDOM_ITEMS   = 100;
  localparam int RX_HOLD_CYCLES = 300;
  localparam logic [7:0] ESC_SET [8] = '{CH_LOWER_N, CH_LOWER_R, CH_LOWER_T, CH_QUOTE,
                                          CH_BSLASH, CH_SLASH, CH_LOWER_B, CH_LOWER_F};

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  int   fails;
  int   pending;
  int   checked;
  int   items_sent  = 0;
  int   strings_sent = 0;
  int   burst_left  = 0;
  bit   hold_rx_req = 1'b0;
  logic [7:0] str_q [$];

  json_string_unescape_utf8 dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  jsu_decode_checker checker_i (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_data_i  (out_data),
    .errors_o    (fails),
    .pending_o   (pending),
    .checked_o   (checked)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("%0t: timeout with %0d decoded bytes outstanding", $time, pending);
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    int phase_left;
    int pattern;
    phase_left = 0;
    pattern    = 0;
    forever begin
      @(negedge clk);
      if (hold_rx_req) begin
        out_stall <= 1'b1;
        repeat (RX_HOLD_CYCLES) @(negedge clk);
        hold_rx_req = 1'b0;
      end
      if (phase_left == 0) begin
        pattern    = $urandom_range(0, 3);
        phase_left = $urandom_range(20, 80);
      end
      phase_left--;
      case (pattern)
        0:       out_stall <= 1'b0;
        1:       out_stall <= ($urandom_range(0, 3) == 0);
        2:       out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= (phase_left % 4 < 2);
      endcase
    end
  end

  task automatic put_byte(input logic [7:0] b, input logic last);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= '{in_byte: b, in_last: last};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_string();
    foreach (str_q[i]) put_byte(str_q[i], i == str_q.size() - 1);
    strings_sent++;
    str_q.delete();
  endtask

  task automatic drain_sender();
    @(negedge clk);
    in_valid <= 1'b0;
    wait (pending == 0);
  endtask

  function automatic logic [7:0] hex_char(logic [3:0] n);
    if (n < 4'd10) return CH_DIGIT_0 + 8'(n);
    return ($urandom_range(0, 1) ? CH_UPPER_A : CH_LOWER_A) + 8'(n - 4'd10);
  endfunction

  function automatic void add_unicode(logic [15:0] code);
    str_q.push_back(CH_BSLASH);
    str_q.push_back(CH_LOWER_U);
    for (int i = 3; i >= 0; i--) str_q.push_back(hex_char(code[4*i +: 4]));
  endfunction

  function automatic void add_bad_u();
    str_q.push_back(CH_BSLASH);
    str_q.push_back(CH_LOWER_U);
    repeat ($urandom_range(0, 3)) str_q.push_back(hex_char(4'($urandom_range(0, 15))));
    str_q.push_back(8'($urandom_range(8'h67, 8'h7A)));
  endfunction

  function automatic void add_token();
    int          kind;
    logic [15:0] code;
    kind = $urandom_range(0, 19);
    if (kind <= 5) begin
      str_q.push_back(8'($urandom_range(0, 255)));
    end else if (kind <= 8) begin
      str_q.push_back(CH_BSLASH);
      str_q.push_back(ESC_SET[$urandom_range(0, 7)]);
    end else if (kind == 9) begin
      str_q.push_back(CH_BSLASH);
      str_q.push_back(8'($urandom_range(0, 255)));
    end else if (kind <= 12) begin
      case ($urandom_range(0, 2))
        0: code = 16'($urandom_range(0, 16'h7F));
        1: code = 16'($urandom_range(16'h80, 16'h7FF));
        default: begin
          code = 16'($urandom_range(16'h800, 16'hFFFF));
          if (code >= HI_SUR_MIN && code <= LO_SUR_MAX) code ^= 16'h4000;
        end
      endcase
      add_unicode(code);
    end else if (kind <= 14) begin
      add_unicode(16'($urandom_range(HI_SUR_MIN, HI_SUR_MAX)));
      add_unicode(16'($urandom_range(LO_SUR_MIN, LO_SUR_MAX)));
    end else if (kind == 15) begin
      add_unicode(16'($urandom_range(LO_SUR_MIN, LO_SUR_MAX)));
    end else if (kind == 16) begin
      add_unicode(16'($urandom_range(HI_SUR_MIN, HI_SUR_MAX)));
      case ($urandom_range(0, 3))
        0: str_q.push_back(8'($urandom_range(0, 255)));
        1: begin
          str_q.push_back(CH_BSLASH);
          str_q.push_back(8'($urandom_range(0, 255)));
        end
        2:       add_unicode(16'($urandom_range(0, HI_SUR_MAX)));
        default: add_bad_u();
      endcase
    end else if (kind == 17) begin
      add_bad_u();
    end else if (kind == 18) begin
      str_q.push_back(CH_BSLASH);
    end else begin
      str_q.push_back(CH_BSLASH);
      str_q.push_back(CH_LOWER_U);
      repeat (4) str_q.push_back(8'($urandom_range(0, 255)));
    end
  endfunction

  initial begin
    int start_items;
    int cut;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    str_q = '{8'h00, CH_BSLASH, CH_LOWER_N, 8'hFF};
    send_string();
    add_unicode(16'hD83D);
    add_unicode(16'hDE00);
    send_string();
    add_unicode(16'hD800);
    str_q.push_back(CH_BSLASH);
    str_q.push_back(8'h71);
    send_string();
    drain_sender();

    start_items = items_sent;
    while (items_sent - start_items < RANDOM_ITEMS) begin
      repeat ($urandom_range(1, 8)) add_token();
      if ($urandom_range(0, 3) == 0) begin
        cut = $urandom_range(1, 4);
        while (cut > 0 && str_q.size() > 1) begin
          void'(str_q.pop_back());
          cut--;
        end
      end
      if (strings_sent == 4) hold_rx_req = 1'b1;
      if (strings_sent % 6 == 5) drain_sender();
      send_string();
    end

    drain_sender();
    repeat (20) @(posedge clk);
    $display("Sent %0d bytes in %0d strings; %0d decoded bytes checked across escapes,",
             items_sent, strings_sent, checked);
    $display("unicode and surrogate pairs, failed escapes, truncated ends and output stalls.");
    if (fails == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== json_string_unescape_utf8.f =====
+incdir+sv
sv/jsu_pkg.sv
sv/jsu_front.sv
sv/jsu_queue.sv
sv/jsu_back.sv
sv/json_string_unescape_utf8.sv
tb/json_string_unescape_utf8_checker.sv
tb/json_string_unescape_utf8_tb.sv
